FILE: rtl/core/utdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_pkg: shared types and codes for the uncommitted key collector
// Holds opcodes, status codes, modes and the controller state type.
// ----------------------------------------------------------------------------
package utdc_pkg;

  localparam int unsigned KeyW = 63;

  typedef enum logic [1:0] {
    OP_ROW   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COL_OUT  = 2'd1,
    ST_BAD_KEY  = 2'd2,
    ST_IDX_OUT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_SEQ = 2'd0,
    MODE_ID  = 2'd1,
    MODE_OVF = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MERGE,
    S_RETRY,
    S_OUT
  } state_e;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic clear;    // drop all entries
    logic append;   // store the probe key at the tail
    logic zero_seq; // zero every stored sequence
    logic compact;  // one merge step: shift out a marked duplicate
  } cell_ctl_t;

endpackage

FILE: rtl/core/utdc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_cell: one slot of the key chain
// Holds one key, compares it with the probe, and takes the next cell's key
// when the chain compacts.
// ----------------------------------------------------------------------------
module utdc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  utdc_pkg::cell_ctl_t                ctl_i,
  input  logic                               is_tail_i,   // first free slot
  input  logic                               kill_i,      // marked dup at or below
  input  logic [utdc_pkg::KeyW-1:0]          probe_id_i,
  input  logic [utdc_pkg::KeyW-1:0]          probe_seq_i,
  input  logic                               nxt_valid_i,
  input  logic [utdc_pkg::KeyW-1:0]          nxt_id_i,
  input  logic [utdc_pkg::KeyW-1:0]          nxt_seq_i,
  input  logic                               prev_dup_i,  // an earlier cell has my id
  output logic                               valid_o,
  output logic [utdc_pkg::KeyW-1:0]          id_o,
  output logic [utdc_pkg::KeyW-1:0]          seq_o,
  output logic                               hit_o,
  output logic                               dup_o
);

  logic                        valid_q, valid_d;
  logic [utdc_pkg::KeyW-1:0]   id_q, id_d, seq_q, seq_d;

  assign hit_o = valid_q && (id_q == probe_id_i) && (seq_q == probe_seq_i);
  assign dup_o = valid_q && prev_dup_i;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    seq_d   = seq_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.zero_seq) begin
      seq_d = '0;
    end else if (ctl_i.compact && kill_i) begin
      // take the neighbor's key, closing the gap
      valid_d = nxt_valid_i;
      id_d    = nxt_id_i;
      seq_d   = nxt_seq_i;
    end else if (ctl_i.append && is_tail_i) begin
      valid_d = 1'b1;
      id_d    = probe_id_i;
      seq_d   = probe_seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    seq_q <= seq_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign seq_o   = seq_q;

endmodule

FILE: rtl/core/uncommitted_txn_dedup_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uncommitted_txn_dedup_collector: deduplicating key collector
// Keeps an insertion-ordered set of (txn id, sequence) keys in a chain of
// cells, with a row total and record-sequence / id-only / overflow modes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | op, is_uncommitted, txn_id, ...
//  out     | output    | out_valid/out_stall | status, mode, entry_count, ...
//  cfg     | input     | cfg_we_i          | cfg_wdata_i (seq_column_index)
//
//  A beat goes through accept, parallel compare in the cell chain, and result.
//  A full set in record-sequence mode adds the merge, which ends with a final
//  merge check and the retry, with merged duplicates shifted out one a cycle.
//  Reset clears the cells' valid bits at once; no clearing pass.
//  Input is stalled from accept until the result beat is taken.
module uncommitted_txn_dedup_collector #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [11:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic                          is_uncommitted_i,
  input  logic [62:0]                   txn_id_i,
  input  logic [62:0]                   seq_value_i,
  input  logic [11:0]                   column_count_i,
  input  logic [7:0]                    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [1:0]                    mode_o,
  output logic [8:0]                    entry_count_o,
  output logic [31:0]                   row_total_o,
  output logic [62:0]                   entry_txn_id_o,
  output logic [62:0]                   entry_seq_o
);

  localparam int unsigned N  = MAX_ENTRIES;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  utdc_pkg::state_e state_q, state_d;
  utdc_pkg::mode_e  mode_q, mode_d;
  logic [11:0]      col_idx_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [31:0]      total_q, total_d;
  logic [62:0]      pid_q, pid_d, pseq_q, pseq_d;
  logic [1:0]       op_q;
  logic [7:0]       ridx_q;
  logic             unc_q;
  logic [11:0]      cols_q;
  logic [1:0]       st_q, st_d;
  logic [62:0]      eid_q, eid_d, eseq_q, eseq_d;
  utdc_pkg::cell_ctl_t ctl;

  logic [N-1:0]        c_valid, c_hit, c_dup, c_prev_dup, c_kill, c_tail;
  logic [62:0]         c_id  [N];
  logic [62:0]         c_seq [N];

  // Duplicate detection in id-only merge: a cell is a dup if any earlier
  // valid cell holds the same id (sequences are already zero).
  always_comb begin
    for (int i = 0; i < N; i++) begin
      c_prev_dup[i] = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (c_valid[j] && c_id[j] == c_id[i]) c_prev_dup[i] = 1'b1;
      end
    end
  end

  // kill: at or after the first dup, so the chain shifts from there.
  always_comb begin
    c_kill[0] = c_dup[0];
    for (int i = 1; i < N; i++) c_kill[i] = c_kill[i-1] | c_dup[i];
    for (int i = 0; i < N; i++) c_tail[i] = (cnt_q == CW'(i));
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic        nv;
    logic [62:0] nid, nseq;
    if (g == N - 1) begin : g_last
      assign nv = 1'b0; assign nid = '0; assign nseq = '0;
    end else begin : g_mid
      assign nv = c_valid[g+1]; assign nid = c_id[g+1]; assign nseq = c_seq[g+1];
    end
    utdc_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl), .is_tail_i(c_tail[g]), .kill_i(c_kill[g]),
      .probe_id_i(pid_q), .probe_seq_i(pseq_q),
      .nxt_valid_i(nv), .nxt_id_i(nid), .nxt_seq_i(nseq),
      .prev_dup_i(c_prev_dup[g]),
      .valid_o(c_valid[g]), .id_o(c_id[g]), .seq_o(c_seq[g]),
      .hit_o(c_hit[g]), .dup_o(c_dup[g])
    );
  end

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != utdc_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    pid_d   = pid_q;
    pseq_d  = pseq_q;
    st_d    = st_q;
    eid_d   = eid_q;
    eseq_d  = eseq_q;
    ctl     = '0;
    unique case (state_q)
      utdc_pkg::S_IDLE: begin
        if (in_acc) begin
          pid_d   = txn_id_i;
          pseq_d  = (mode_q == utdc_pkg::MODE_ID) ? '0 : seq_value_i;
          state_d = utdc_pkg::S_LOOK;
        end
      end
      utdc_pkg::S_LOOK, utdc_pkg::S_RETRY: begin
        st_d    = utdc_pkg::ST_OK;
        eid_d   = '0;
        eseq_d  = '0;
        state_d = utdc_pkg::S_OUT;
        unique case (op_q)
          utdc_pkg::OP_ROW: begin
            if (state_q == utdc_pkg::S_RETRY) begin
              if (c_hit == '0) begin
                if (cnt_q < CW'(N)) begin
                  ctl.append = 1'b1;
                  cnt_d      = cnt_q + 1'b1;
                end else begin
                  ctl.clear = 1'b1; cnt_d = '0; total_d = '0;
                  mode_d = utdc_pkg::MODE_OVF;
                end
              end
            end else if (col_idx_q >= cols_q) begin
              st_d = utdc_pkg::ST_COL_OUT;
            end else if (unc_q) begin
              if (total_q != 32'hFFFF_FFFF) total_d = total_q + 32'd1;
              if (pid_q == '0) begin
                st_d = utdc_pkg::ST_BAD_KEY;
              end else if (mode_q != utdc_pkg::MODE_OVF && c_hit == '0) begin
                if (cnt_q < CW'(N)) begin
                  ctl.append = 1'b1;
                  cnt_d      = cnt_q + 1'b1;
                end else if (mode_q == utdc_pkg::MODE_SEQ) begin
                  ctl.zero_seq = 1'b1;
                  pseq_d       = '0;
                  mode_d       = utdc_pkg::MODE_ID;
                  state_d      = utdc_pkg::S_MERGE;
                end else begin
                  ctl.clear = 1'b1; cnt_d = '0; total_d = '0;
                  mode_d = utdc_pkg::MODE_OVF;
                end
              end
            end
          end
          utdc_pkg::OP_READ: begin
            if ({1'b0, ridx_q} < 9'(cnt_q) && {1'b0, ridx_q} < 9'(N)) begin
              eid_d  = c_id[ridx_q[IW-1:0]];
              eseq_d = c_seq[ridx_q[IW-1:0]];
            end else begin
              st_d = utdc_pkg::ST_IDX_OUT;
            end
          end
          utdc_pkg::OP_CLEAR: begin
            ctl.clear = 1'b1; cnt_d = '0; total_d = '0;
            mode_d = utdc_pkg::MODE_SEQ;
          end
          default: ;
        endcase
      end
      utdc_pkg::S_MERGE: begin
        // shift out one duplicate per cycle
        if (c_dup != '0) begin
          ctl.compact = 1'b1;
          cnt_d       = cnt_q - 1'b1;
        end else begin
          state_d = utdc_pkg::S_RETRY;
        end
      end
      utdc_pkg::S_OUT: begin
        if (!out_stall_i) state_d = utdc_pkg::S_IDLE;
      end
      default: state_d = utdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= utdc_pkg::S_IDLE;
      mode_q    <= utdc_pkg::MODE_SEQ;
      cnt_q     <= '0;
      total_q   <= '0;
      col_idx_q <= 12'd1;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      if (cfg_we_i) col_idx_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q  <= pid_d;
    pseq_q <= pseq_d;
    st_q   <= st_d;
    eid_q  <= eid_d;
    eseq_q <= eseq_d;
    if (in_acc) begin
      op_q   <= op_i;
      unc_q  <= is_uncommitted_i;
      cols_q <= column_count_i;
      ridx_q <= read_index_i;
    end
  end

  assign out_valid_o    = (state_q == utdc_pkg::S_OUT);
  assign status_o       = st_q;
  assign mode_o         = mode_q;
  assign entry_count_o  = 9'(cnt_q);
  assign row_total_o    = total_q;
  assign entry_txn_id_o = eid_q;
  assign entry_seq_o    = eseq_q;

endmodule

FILE: rtl/core/utdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utdc_checker: port-level checks for the key collector
// Watches the top-level ports and flags broken result beats.
// ----------------------------------------------------------------------------
module utdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [1:0]  mode_o,
  input logic [8:0]  entry_count_o,
  input logic [62:0] entry_txn_id_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result beat dropped under stall");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_ovf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == utdc_pkg::MODE_OVF |-> entry_count_o == 9'd0)
    else $error("overflow mode with stored keys");

  a_err_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != utdc_pkg::ST_OK |-> entry_txn_id_o == '0)
    else $error("entry data on error status");

endmodule

bind uncommitted_txn_dedup_collector utdc_checker u_utdc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .mode_o, .entry_count_o, .entry_txn_id_o
);

FILE: test/tb_uncommitted_txn_dedup_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uncommitted_txn_dedup_collector: self-checking bench for the key collector
// Drives a directed table and then random row, read, clear and unused-op beats with
// random gaps and stalls, predicts or looks up every result and compares field by field.
// ----------------------------------------------------------------------------
module tb_uncommitted_txn_dedup_collector;

  localparam int unsigned Depth = 32;

  typedef struct packed {
    logic [1:0]  op;
    logic        unc;
    logic [62:0] id;
    logic [62:0] seq;
    logic [11:0] cols;
    logic [7:0]  ridx;
  } beat_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [8:0]  count;
    logic [31:0] total;
    logic [62:0] eid;
    logic [62:0] eseq;
  } beat_out_t;

  typedef struct {
    beat_in_t  stim;
    logic      has_exp;
    beat_out_t exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = 12'd1;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic        is_uncommitted_i = 1'b0;
  logic [62:0] txn_id_i = '0;
  logic [62:0] seq_value_i = '0;
  logic [11:0] column_count_i = '0;
  logic [7:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  mode_o;
  logic [8:0]  entry_count_o;
  logic [31:0] row_total_o;
  logic [62:0] entry_txn_id_o;
  logic [62:0] entry_seq_o;

  uncommitted_txn_dedup_collector #(.MAX_ENTRIES(Depth)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .op_i, .is_uncommitted_i, .txn_id_i, .seq_value_i, .column_count_i,
    .read_index_i, .out_valid_o, .out_stall_i, .status_o, .mode_o,
    .entry_count_o, .row_total_o, .entry_txn_id_o, .entry_seq_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [62:0]       pr_ids [Depth];
  logic [62:0]       pr_seqs[Depth];
  int unsigned       pr_count;
  utdc_pkg::mode_e   pr_mode;
  logic [31:0]       pr_total;
  logic [11:0]       pr_col_idx;

  beat_out_t   pending_q[$];
  int unsigned mismatches = 0;
  bit          drive_done = 1'b0;

  function automatic bit key_present(logic [62:0] id, logic [62:0] seq);
    for (int unsigned i = 0; i < pr_count; i++) begin
      if (pr_ids[i] == id && pr_seqs[i] == seq) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void insert_key(logic [62:0] id, logic [62:0] seq);
    int unsigned n;
    if (pr_mode == utdc_pkg::MODE_OVF) return;
    if (pr_mode == utdc_pkg::MODE_ID) seq = '0;
    if (key_present(id, seq)) return;
    if (pr_count < Depth) begin
      pr_ids[pr_count] = id; pr_seqs[pr_count] = seq; pr_count++;
      return;
    end
    if (pr_mode == utdc_pkg::MODE_SEQ) begin
      // zero sequences and fold duplicates, keeping first occurrence
      n = pr_count;
      pr_count = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (!key_present(pr_ids[i], '0)) begin
          pr_ids[pr_count] = pr_ids[i]; pr_seqs[pr_count] = '0; pr_count++;
        end
      end
      pr_mode = utdc_pkg::MODE_ID;
      if (key_present(id, '0)) return;
      if (pr_count < Depth) begin
        pr_ids[pr_count] = id; pr_seqs[pr_count] = '0; pr_count++;
        return;
      end
    end
    pr_count = 0;
    pr_total = '0;
    pr_mode = utdc_pkg::MODE_OVF;
  endfunction

  function automatic beat_out_t collect_step(beat_in_t b);
    beat_out_t r;
    r = '0;
    r.status = utdc_pkg::ST_OK;
    case (utdc_pkg::op_e'(b.op))
      utdc_pkg::OP_ROW: begin
        if (pr_col_idx >= b.cols) r.status = utdc_pkg::ST_COL_OUT;
        else if (b.unc) begin
          if (pr_total != 32'hFFFF_FFFF) pr_total++;
          if (b.id == '0) r.status = utdc_pkg::ST_BAD_KEY;
          else insert_key(b.id, b.seq);
        end
      end
      utdc_pkg::OP_READ: begin
        if (b.ridx < pr_count) begin
          r.eid = pr_ids[b.ridx]; r.eseq = pr_seqs[b.ridx];
        end else r.status = utdc_pkg::ST_IDX_OUT;
      end
      utdc_pkg::OP_CLEAR: begin
        pr_count = 0; pr_total = '0; pr_mode = utdc_pkg::MODE_SEQ;
      end
      default: ;
    endcase
    r.mode = pr_mode;
    r.count = 9'(pr_count);
    r.total = pr_total;
    return r;
  endfunction

  // valid stays up after the accepting edge; drop it only before a gap
  task automatic send_beat(beat_in_t b, int unsigned gap, bit use_exp, beat_out_t want);
    beat_out_t pred;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pred = collect_step(b);
    pending_q.insert(pending_q.size(), use_exp ? want : pred);
    in_valid_i <= 1'b1;
    {op_i, is_uncommitted_i, txn_id_i, seq_value_i, column_count_i, read_index_i} <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_col_idx(logic [11:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pr_col_idx = v;
  endtask

  // keys from a small pool so duplicates and merges happen
  function automatic beat_in_t rand_beat(int unsigned pool);
    beat_in_t b;
    int unsigned r;
    b.op = 2'(utdc_pkg::OP_ROW);
    r = $urandom_range(0, 99);
    if (r < 8) b.op = 2'(utdc_pkg::OP_READ);
    else if (r < 10) b.op = 2'(utdc_pkg::OP_CLEAR);
    else if (r < 11) b.op = 2'(utdc_pkg::OP_NONE);
    b.unc = ($urandom_range(0, 9) != 0);
    b.id = 63'($urandom_range(0, pool));
    if ($urandom_range(0, 15) == 0) b.id = 63'({$urandom, $urandom});
    b.seq = 63'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) b.seq = 63'({$urandom, $urandom});
    b.cols = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'hFFF;
    b.ridx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
    return b;
  endfunction

  row_t plan[$];

  function automatic void add_row(row_t t);
    plan.insert(plan.size(), t);
  endfunction

  function automatic row_t mk(logic [1:0] op, logic unc, logic [62:0] id, logic [62:0] seq,
                              logic [11:0] cols, logic [7:0] ridx, logic he, beat_out_t e);
    row_t t;
    t.stim = {op, unc, id, seq, cols, ridx};
    t.has_exp = he;
    t.exp = e;
    return t;
  endfunction

  initial begin
    beat_out_t z;
    z = '0;
    pr_count = 0; pr_mode = utdc_pkg::MODE_SEQ; pr_total = '0; pr_col_idx = 12'd1;
    // read on empty set, bad column, zero id, extremes, committed, unused op
    add_row(mk(utdc_pkg::OP_READ, 0, 0, 0, 0, 8'hFF, 1,
               '{utdc_pkg::ST_IDX_OUT, utdc_pkg::MODE_SEQ, 0, 0, 0, 0}));
    add_row(mk(utdc_pkg::OP_ROW, 1, 5, 5, 12'd1, 0, 1,
               '{utdc_pkg::ST_COL_OUT, utdc_pkg::MODE_SEQ, 0, 0, 0, 0}));
    add_row(mk(utdc_pkg::OP_ROW, 1, 0, 7, 12'd2, 0, 1,
               '{utdc_pkg::ST_BAD_KEY, utdc_pkg::MODE_SEQ, 0, 1, 0, 0}));
    add_row(mk(utdc_pkg::OP_ROW, 1, '1, '1, 12'hFFF, 0, 0, z));
    add_row(mk(utdc_pkg::OP_ROW, 1, '1, '1, 12'hFFF, 0, 0, z));
    add_row(mk(utdc_pkg::OP_ROW, 0, 9, 9, 12'hFFF, 0, 0, z));
    add_row(mk(utdc_pkg::OP_READ, 0, 0, 0, 0, 0, 1,
               '{utdc_pkg::ST_OK, utdc_pkg::MODE_SEQ, 1, 3, '1, '1}));
    add_row(mk(utdc_pkg::OP_NONE, 1, '1, '1, 12'hFFF, 8'hFF, 0, z));
    add_row(mk(utdc_pkg::OP_READ, 0, 0, 0, 0, 1, 0, z));
    add_row(mk(utdc_pkg::OP_CLEAR, 1, '1, '1, 12'hFFF, 8'hFF, 1,
               '{utdc_pkg::ST_OK, utdc_pkg::MODE_SEQ, 0, 0, 0, 0}));
    // fill, merge into id-only, then overflow
    for (int i = 1; i <= 20; i++) begin
      add_row(mk(utdc_pkg::OP_ROW, 1, 63'(i), 63'(1), 12'hFFF, 0, 0, z));
      add_row(mk(utdc_pkg::OP_ROW, 1, 63'(i), 63'(2), 12'hFFF, 0, 0, z));
    end
    add_row(mk(utdc_pkg::OP_READ, 0, 0, 0, 0, 8'd5, 0, z));
    for (int i = 21; i <= 40; i++) begin
      add_row(mk(utdc_pkg::OP_ROW, 1, 63'(i), 3, 12'hFFF, 0, 0, z));
    end
    add_row(mk(utdc_pkg::OP_ROW, 1, 77, 3, 12'hFFF, 0, 0, z));
    add_row(mk(utdc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, z));
    add_row(mk(utdc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, z));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      send_beat(plan[k].stim, $urandom_range(0, 15), plan[k].has_exp, plan[k].exp);
    end

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: write_col_idx(12'd4095);
        1: write_col_idx(12'd0);
        2: write_col_idx(12'($urandom_range(1, 20)));
        default: write_col_idx(12'd1);
      endcase
      for (int n = 0; n < 195; n++) begin
        send_beat(rand_beat(ph == 4 ? 60 : 40),
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15), 1'b0, z);
        if (n == 100 && ph == 2) wait_idle();
      end
    end
    wait_idle();
    drive_done = 1'b1;
  end

  // result side: random stall, check on accept
  initial begin
    int unsigned hold;
    beat_out_t got, want;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{status_o, mode_o, entry_count_o, row_total_o, entry_txn_id_o, entry_seq_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    wait (drive_done);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** uncommitted_txn_dedup_collector: PASSED **");
    end else begin
      $display("** uncommitted_txn_dedup_collector: FAILED **");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("** uncommitted_txn_dedup_collector: FAILED **");
    $finish;
  end

endmodule

FILE: uncommitted_txn_dedup_collector.f
rtl/core/utdc_pkg.sv
rtl/core/utdc_cell.sv
rtl/core/uncommitted_txn_dedup_collector.sv
rtl/core/utdc_checker.sv
test/tb_uncommitted_txn_dedup_collector.sv
